// ----- design/midi_note_pairing_recorder_assert.svh -----
// Assertion macros for the MIDI note pairing recorder.
`ifndef MIDI_NOTE_PAIRING_RECORDER_ASSERT_SVH
`define MIDI_NOTE_PAIRING_RECORDER_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication, sampled on clk, off while rst_n is low
`define MNPR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mnpr assertion failed");
// next-cycle implication
`define MNPR_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mnpr assertion failed");
`else
`define MNPR_ASSERT_IMP(label, ante, cons)
`define MNPR_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ----- design/mnpr_pkg.sv -----
// Types and constants of the MIDI note pairing recorder.
package mnpr_pkg;

    localparam int PENDING_DEPTH_DEF = 16;
    localparam int MAX_RESULTS       = 16;

    localparam logic [31:0] NOTE_OFF_MIN_TICKS = 32'd96;
    localparam logic [31:0] FLUSH_MIN_TICKS    = 32'd120;

    localparam logic [1:0] CMD_MIDI  = 2'd0;
    localparam logic [1:0] CMD_FLUSH = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [3:0] STAT_NOTE_OFF = 4'h8;
    localparam logic [3:0] STAT_NOTE_ON  = 4'h9;

    localparam logic KIND_NOTE = 1'b0;
    localparam logic KIND_DROP = 1'b1;

    typedef struct packed {
        logic [6:0]  note;
        logic [3:0]  chan;
        logic [6:0]  vel;
        logic [31:0] start;
    } pend_entry_t;

    typedef struct packed {
        logic        kind;
        logic [3:0]  chan;
        logic [6:0]  note;
        logic [6:0]  vel;
        logic [31:0] start;
        logic [31:0] dur;
        logic        last;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DROP,
        ST_SEARCH,
        ST_SHIFT,
        ST_FLUSH
    } rec_state_t;

endpackage

// ----- design/midi_note_pairing_recorder.sv -----
// MIDI note pairing recorder: pending-note memory with search, shift and flush sequencing.
// Sequence: a drop or a flush loads the result register from the DROP or FLUSH state once the
//   output is free; a note-off reads entries (one memory access each) from address 0 until one
//   matches, then shifts the later entries down; flush items follow one a cycle while out_ready stays high.
// Acceptance: one item at a time; in_ready is low in the drop, search, shift and flush states.
// Reset: control, count and record_enable clear at once; entry memory is left undefined.
`include "midi_note_pairing_recorder_assert.svh"

module midi_note_pairing_recorder #(
    parameter int PENDING_DEPTH = mnpr_pkg::PENDING_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        record_enable,
    // input items
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [7:0]  status_byte,
    input  logic [6:0]  note_number,
    input  logic [6:0]  note_velocity,
    input  logic [31:0] beat_time,
    // result items
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [3:0]  channel,
    output logic [6:0]  note_out,
    output logic [6:0]  velocity_out,
    output logic [31:0] start_time,
    output logic [31:0] duration,
    output logic        last
);

    // address width of the entry memory, count width holds 0..PENDING_DEPTH
    localparam int AW    = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int CNT_W = $clog2(PENDING_DEPTH + 1);

    // length of a note, or the given minimum when end is not after start
    function automatic logic [31:0] note_len(input logic [31:0] end_t,
                                             input logic [31:0] start_t,
                                             input logic [31:0] min_t);
        logic [31:0] diff;
        diff = end_t - start_t;
        return (end_t > start_t) ? diff : min_t;
    endfunction

    // state registers
    mnpr_pkg::rec_state_t  state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [CNT_W-1:0]      lim_reg, lim_next;
    logic                  en_reg, en_next;
    mnpr_pkg::pend_entry_t key_reg, key_next;
    mnpr_pkg::result_t     out_reg, out_next;
    logic                  out_valid_reg, out_valid_next;

    // pending-entry memory, oldest entry at address 0
    mnpr_pkg::pend_entry_t mem [PENDING_DEPTH];
    mnpr_pkg::pend_entry_t rd_data_reg;
    logic                  rd_en, wr_en;
    logic [AW-1:0]         rd_addr, wr_addr;
    mnpr_pkg::pend_entry_t wr_data;

    // decode and helpers
    mnpr_pkg::pend_entry_t in_entry;
    logic                  in_acc;
    logic                  is_on, is_off, full, out_free, match;
    logic [CNT_W:0]        idx_inc, idx_inc2, cnt_ext;
    logic [CNT_W-1:0]      flush_lim;

    assign in_acc   = in_valid && in_ready;
    assign in_entry = '{note: note_number, chan: status_byte[3:0],
                        vel: note_velocity, start: beat_time};
    assign is_on    = (status_byte[7:4] == mnpr_pkg::STAT_NOTE_ON) && (note_velocity != 7'd0);
    assign is_off   = (status_byte[7:4] == mnpr_pkg::STAT_NOTE_OFF)
                   || ((status_byte[7:4] == mnpr_pkg::STAT_NOTE_ON) && (note_velocity == 7'd0));
    assign full     = (count_reg == CNT_W'(PENDING_DEPTH));
    assign out_free = !out_valid_reg || out_ready;
    assign match    = (rd_data_reg.note == key_reg.note) && (rd_data_reg.chan == key_reg.chan);
    assign idx_inc  = {1'b0, idx_reg} + (CNT_W+1)'(1);
    assign idx_inc2 = {1'b0, idx_reg} + (CNT_W+1)'(2);
    assign cnt_ext  = {1'b0, count_reg};
    // a flush gives at most MAX_RESULTS items; anything beyond is discarded
    assign flush_lim = (32'(count_reg) > mnpr_pkg::MAX_RESULTS)
                     ? CNT_W'(mnpr_pkg::MAX_RESULTS) : count_reg;

    assign in_ready  = (state_reg == mnpr_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mnpr_pkg::ST_IDLE:
            begin
                if (in_acc && en_reg)
                begin
                    if (cmd == mnpr_pkg::CMD_MIDI)
                    begin
                        if (is_on && full)
                            state_next = mnpr_pkg::ST_DROP;
                        else if (is_off && count_reg != '0)
                            state_next = mnpr_pkg::ST_SEARCH;
                    end
                    else if (cmd == mnpr_pkg::CMD_FLUSH && count_reg != '0)
                        state_next = mnpr_pkg::ST_FLUSH;
                end
            end
            mnpr_pkg::ST_DROP:
            begin
                if (out_free)
                    state_next = mnpr_pkg::ST_IDLE;
            end
            mnpr_pkg::ST_SEARCH:
            begin
                if (match)
                begin
                    if (out_free)
                        state_next = (idx_inc < cnt_ext) ? mnpr_pkg::ST_SHIFT
                                                         : mnpr_pkg::ST_IDLE;
                end
                else if (!(idx_inc < cnt_ext))
                    state_next = mnpr_pkg::ST_IDLE;
            end
            mnpr_pkg::ST_SHIFT:
            begin
                if (!(idx_inc2 < cnt_ext))
                    state_next = mnpr_pkg::ST_IDLE;
            end
            mnpr_pkg::ST_FLUSH:
            begin
                if (out_free && idx_inc == {1'b0, lim_reg})
                    state_next = mnpr_pkg::ST_IDLE;
            end
            default: state_next = mnpr_pkg::ST_IDLE;
        endcase
    end

    // datapath, memory control and result register loading
    always_comb
    begin
        count_next     = count_reg;
        idx_next       = idx_reg;
        lim_next       = lim_reg;
        en_next        = en_reg;
        key_next       = key_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = count_reg[AW-1:0];
        wr_data        = in_entry;

        unique case (state_reg)
            mnpr_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    key_next = in_entry;
                    idx_next = '0;
                    case (cmd)
                        mnpr_pkg::CMD_CLEAR:
                            count_next = '0;
                        mnpr_pkg::CMD_FLUSH:
                        begin
                            if (en_reg)
                            begin
                                en_next    = 1'b0;
                                lim_next   = flush_lim;
                                count_next = '0;
                                rd_en      = 1'b1;
                            end
                        end
                        mnpr_pkg::CMD_MIDI:
                        begin
                            if (en_reg)
                            begin
                                if (is_on && !full)
                                begin
                                    wr_en      = 1'b1;
                                    count_next = count_reg + CNT_W'(1);
                                end
                                else if (is_off && count_reg != '0)
                                    rd_en = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            mnpr_pkg::ST_DROP:
            begin
                if (out_free)
                begin
                    out_next = '{kind: mnpr_pkg::KIND_DROP, chan: key_reg.chan,
                                 note: key_reg.note, vel: key_reg.vel,
                                 start: key_reg.start, dur: 32'd0, last: 1'b1};
                    out_valid_next = 1'b1;
                end
            end
            mnpr_pkg::ST_SEARCH:
            begin
                if (match)
                begin
                    if (out_free)
                    begin
                        out_next = '{kind: mnpr_pkg::KIND_NOTE, chan: rd_data_reg.chan,
                                     note: rd_data_reg.note, vel: rd_data_reg.vel,
                                     start: rd_data_reg.start,
                                     dur: note_len(key_reg.start, rd_data_reg.start,
                                                   mnpr_pkg::NOTE_OFF_MIN_TICKS),
                                     last: 1'b1};
                        out_valid_next = 1'b1;
                        if (idx_inc < cnt_ext)
                        begin
                            // close the gap: fetch the next entry for the shift
                            rd_en   = 1'b1;
                            rd_addr = idx_inc[AW-1:0];
                        end
                        else
                            count_next = count_reg - CNT_W'(1);
                    end
                end
                else if (idx_inc < cnt_ext)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_inc[AW-1:0];
                    idx_next = idx_inc[CNT_W-1:0];
                end
            end
            mnpr_pkg::ST_SHIFT:
            begin
                // entry idx+1 is in the read register; move it down to idx
                wr_en   = 1'b1;
                wr_addr = idx_reg[AW-1:0];
                wr_data = rd_data_reg;
                if (idx_inc2 < cnt_ext)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_inc2[AW-1:0];
                    idx_next = idx_inc[CNT_W-1:0];
                end
                else
                    count_next = count_reg - CNT_W'(1);
            end
            mnpr_pkg::ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_next = '{kind: mnpr_pkg::KIND_NOTE, chan: rd_data_reg.chan,
                                 note: rd_data_reg.note, vel: rd_data_reg.vel,
                                 start: rd_data_reg.start,
                                 dur: note_len(key_reg.start, rd_data_reg.start,
                                               mnpr_pkg::FLUSH_MIN_TICKS),
                                 last: (idx_inc == {1'b0, lim_reg})};
                    out_valid_next = 1'b1;
                    if (idx_inc != {1'b0, lim_reg})
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = idx_inc[AW-1:0];
                        idx_next = idx_inc[CNT_W-1:0];
                    end
                end
            end
            default: ;
        endcase

        if (cfg_valid)
            en_next = record_enable;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mnpr_pkg::ST_IDLE;
            count_reg     <= '0;
            en_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            en_reg        <= en_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        lim_reg <= lim_next;
        key_reg <= key_next;
        out_reg <= out_next;
    end

    // entry memory, one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign out_valid    = out_valid_reg;
    assign kind         = out_reg.kind;
    assign channel      = out_reg.chan;
    assign note_out     = out_reg.note;
    assign velocity_out = out_reg.vel;
    assign start_time   = out_reg.start;
    assign duration     = out_reg.dur;
    assign last         = out_reg.last;

    // a shift always has a later entry still to move
    `MNPR_ASSERT_IMP(a_shift_in_range, state_reg == mnpr_pkg::ST_SHIFT, idx_inc < cnt_ext)
    // the list is emptied as soon as a flush starts
    `MNPR_ASSERT_IMP(a_flush_count_zero, state_reg == mnpr_pkg::ST_FLUSH, count_reg == '0)
    // a clear empties the list on the next cycle
    `MNPR_ASSERT_NXT(a_clear_empties, in_acc && cmd == mnpr_pkg::CMD_CLEAR, count_reg == '0)
    // a found match is presented as a completed note
    `MNPR_ASSERT_NXT(a_match_emits, state_reg == mnpr_pkg::ST_SEARCH && match && out_free, out_valid_reg && out_reg.kind == mnpr_pkg::KIND_NOTE && out_reg.last)

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for the MIDI note pairing recorder: stimulus, prediction, result checks.
`timescale 1ns / 100ps

module testbench;

    // Run limits. A note-off can keep the block busy searching and shifting pending entries
    // with no item to show for it, so the quiet wait covers a full 16-entry search and shift.
    localparam int CYCLE_LIMIT   = 2000000;
    localparam int SETTLE_CYCLES = 48;
    localparam int ITEM_TARGET   = 330;
    localparam int HOLD_PHASE    = 2;
    localparam int HOLD_CYCLES   = 300;

    // command code with no meaning, expected to be ignored
    localparam logic [1:0] CMD_SPARE = 2'd3;

    // One input item as queued for the driver.
    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  status;
        logic [6:0]  note;
        logic [6:0]  vel;
        logic [31:0] stamp;
    } midi_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        record_enable = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  cmd = mnpr_pkg::CMD_MIDI;
    logic [7:0]  status_byte = 8'h00;
    logic [6:0]  note_number = 7'd0;
    logic [6:0]  note_velocity = 7'd0;
    logic [31:0] beat_time = 32'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        kind;
    logic [3:0]  channel;
    logic [6:0]  note_out;
    logic [6:0]  velocity_out;
    logic [31:0] start_time;
    logic [31:0] duration;
    logic        last;

    // Predictor state: our own copy of record_enable and of the pending-note list.
    logic                  rec_enabled = 1'b0;
    mnpr_pkg::pend_entry_t held_notes[$];
    mnpr_pkg::result_t     expected_notes[$];

    // Driver feed and bookkeeping.
    midi_item_t  stimulus_q[$];
    midi_item_t  cur_item = '0;
    int          queued_total = 0;
    int          accepted_total = 0;
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          send_gap = 0;
    int          drv_calm = 0;
    int          stall_left = 0;
    int          mon_calm = 0;
    logic        stall_hold = 1'b0;
    bit          hold_request = 1'b0;

    midi_note_pairing_recorder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .record_enable (record_enable),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .status_byte   (status_byte),
        .note_number   (note_number),
        .note_velocity (note_velocity),
        .beat_time     (beat_time),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .channel       (channel),
        .note_out      (note_out),
        .velocity_out  (velocity_out),
        .start_time    (start_time),
        .duration      (duration),
        .last          (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Length in ticks, or the floor when the stop time is not after the start.
    function automatic logic [31:0] note_length(logic [31:0] stop_t, logic [31:0] on_t,
                                                logic [31:0] min_len);
        return (stop_t > on_t) ? stop_t - on_t : min_len;
    endfunction

    // Appends one expected result item.
    function automatic void expect_result(mnpr_pkg::result_t r);
        expected_notes.insert(expected_notes.size(), r);
    endfunction

    // Works out what one accepted item does to the pending list and which result items
    // it should produce, in order.
    function automatic void pair_note_event(midi_item_t it);
        mnpr_pkg::pend_entry_t e;
        int                    hit;
        int                    n_emit;
        logic [3:0]            hi;
        hi = it.status[7:4];
        if (it.cmd == mnpr_pkg::CMD_CLEAR)
        begin
            held_notes.delete();
        end
        else if (it.cmd == mnpr_pkg::CMD_FLUSH)
        begin
            // flush only acts while recording, and always stops recording
            if (rec_enabled)
            begin
                rec_enabled = 1'b0;
                n_emit = (held_notes.size() < mnpr_pkg::MAX_RESULTS)
                       ? held_notes.size() : mnpr_pkg::MAX_RESULTS;
                for (int i = 0; i < n_emit; i++)
                begin
                    e = held_notes[i];
                    expect_result(mnpr_pkg::result_t'{mnpr_pkg::KIND_NOTE, e.chan, e.note,
                        e.vel, e.start,
                        note_length(it.stamp, e.start, mnpr_pkg::FLUSH_MIN_TICKS),
                        (i == n_emit - 1)});
                end
                held_notes.delete();
            end
        end
        else if (it.cmd == mnpr_pkg::CMD_MIDI && rec_enabled)
        begin
            if (hi == mnpr_pkg::STAT_NOTE_ON && it.vel != 7'd0)
            begin
                if (held_notes.size() < mnpr_pkg::PENDING_DEPTH_DEF)
                    held_notes.insert(held_notes.size(), mnpr_pkg::pend_entry_t'{it.note,
                        it.status[3:0], it.vel, it.stamp});
                else
                    expect_result(mnpr_pkg::result_t'{mnpr_pkg::KIND_DROP, it.status[3:0],
                        it.note, it.vel, it.stamp, 32'd0, 1'b1});
            end
            else if (hi == mnpr_pkg::STAT_NOTE_OFF || hi == mnpr_pkg::STAT_NOTE_ON)
            begin
                // oldest pending entry with the same note and channel
                hit = -1;
                foreach (held_notes[i])
                    if (hit < 0 && held_notes[i].note == it.note
                        && held_notes[i].chan == it.status[3:0])
                        hit = i;
                if (hit >= 0)
                begin
                    e = held_notes[hit];
                    expect_result(mnpr_pkg::result_t'{mnpr_pkg::KIND_NOTE, e.chan, e.note,
                        e.vel, e.start,
                        note_length(it.stamp, e.start, mnpr_pkg::NOTE_OFF_MIN_TICKS), 1'b1});
                    held_notes.delete(hit);
                end
            end
        end
    endfunction

    // Gap length for either side: mostly none or short, now and then long, and
    // occasionally a calm stretch with no gaps at all.
    function automatic int idle_span(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm = $urandom_range(30, 120);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic queue_item(logic [1:0] c, logic [7:0] s, logic [6:0] n, logic [6:0] v,
                              logic [31:0] t);
        stimulus_q.insert(stimulus_q.size(), midi_item_t'{c, s, n, v, t});
        queued_total++;
    endtask

    // Register write; only called with the block idle.
    task automatic write_record_enable(logic value);
        @(posedge clk);
        cfg_valid     <= 1'b1;
        record_enable <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        rec_enabled = value;
        cfg_valid   <= 1'b0;
    endtask

    // Every queued item accepted, every expected item seen, then let a silent
    // search or shift run out before anything else happens.
    task automatic wait_quiet();
        while (queued_total != accepted_total || expected_notes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Driver: presents queued items, holds them until accepted, and predicts each
    // accepted item at the edge that takes it.
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            pair_note_event(cur_item);
            accepted_total++;
        end
        if (in_valid && !in_ready)
        begin
            // item still on offer, payload held
        end
        else if (send_gap > 0)
        begin
            send_gap--;
            in_valid <= 1'b0;
        end
        else if (stimulus_q.size() != 0)
        begin
            cur_item       = stimulus_q.pop_front();
            cmd           <= cur_item.cmd;
            status_byte   <= cur_item.status;
            note_number   <= cur_item.note;
            note_velocity <= cur_item.vel;
            beat_time     <= cur_item.stamp;
            in_valid      <= 1'b1;
            send_gap       = idle_span(drv_calm);
        end
        else
        begin
            in_valid <= 1'b0;
        end
    end

    // Monitor: checks each accepted result against the oldest expectation and
    // decides the next cycle's ready, with random stalls and the long hold-off.
    always @(posedge clk)
    begin
        mnpr_pkg::result_t want;
        if (out_valid && out_ready)
        begin
            if (expected_notes.size() == 0)
            begin
                $error("result item with nothing expected: note %0d channel %0d",
                       note_out, channel);
                mismatch_count++;
            end
            else
            begin
                want = expected_notes.pop_front();
                check_field("kind", want.kind, kind);
                check_field("channel", want.chan, channel);
                check_field("note_out", want.note, note_out);
                check_field("velocity_out", want.vel, velocity_out);
                check_field("start_time", want.start, start_time);
                check_field("duration", want.dur, duration);
                check_field("last", want.last, last);
            end
        end
        if (stall_hold)
        begin
            out_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            stall_left = idle_span(mon_calm);
        end
    end

    // Long hold-off on the result side while the sender keeps offering, so the
    // block backs up and drops in_ready.
    initial
    begin
        wait (hold_request);
        @(posedge clk);
        stall_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        stall_hold <= 1'b0;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : stimulus
        logic [10:0] gen_notes[$];
        logic [10:0] key;
        logic [31:0] t_now;
        logic [3:0]  chan;
        logic [6:0]  note;
        int          len;
        int          pick;
        int          on_pct;
        int          idx;
        int          phase;
        int          counted;
        bit          gen_on;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Recording off: note events and a flush must all be ignored.
        write_record_enable(1'b0);
        queue_item(mnpr_pkg::CMD_MIDI, {mnpr_pkg::STAT_NOTE_ON, 4'h3}, 7'd60, 7'd100, 32'd10);
        queue_item(mnpr_pkg::CMD_FLUSH, 8'h00, 7'd0, 7'd0, 32'd30);
        wait_quiet();

        // Recording on: field extremes, matching rules and ignored messages.
        write_record_enable(1'b1);
        queue_item(mnpr_pkg::CMD_MIDI, {mnpr_pkg::STAT_NOTE_ON, 4'h0}, 7'd0, 7'd1, 32'd0);
        queue_item(mnpr_pkg::CMD_MIDI, {mnpr_pkg::STAT_NOTE_ON, 4'hF}, 7'd127, 7'd127,
                   32'hFFFF_FFFF);
        queue_item(mnpr_pkg::CMD_MIDI, {mnpr_pkg::STAT_NOTE_ON, 4'h0}, 7'd0, 7'd64, 32'd100);
        // off before its on: floor length
        queue_item(mnpr_pkg::CMD_MIDI, {mnpr_pkg::STAT_NOTE_OFF, 4'hF}, 7'd127, 7'd127, 32'd5);
        // note-on with zero velocity, same tick as the oldest duplicate
        queue_item(mnpr_pkg::CMD_MIDI, {mnpr_pkg::STAT_NOTE_ON, 4'h0}, 7'd0, 7'd0, 32'd0);
        queue_item(mnpr_pkg::CMD_MIDI, {mnpr_pkg::STAT_NOTE_OFF, 4'h0}, 7'd0, 7'd0, 32'd1100);
        // unmatched note-off
        queue_item(mnpr_pkg::CMD_MIDI, {mnpr_pkg::STAT_NOTE_OFF, 4'h5}, 7'd12, 7'd40, 32'd1200);
        // other status bytes and the unused command
        queue_item(mnpr_pkg::CMD_MIDI, 8'hA3, 7'd0, 7'd10, 32'd1300);
        queue_item(mnpr_pkg::CMD_MIDI, 8'hF5, 7'd127, 7'd127, 32'd1400);
        queue_item(mnpr_pkg::CMD_MIDI, 8'h7F, 7'd60, 7'd90, 32'd1500);
        queue_item(CMD_SPARE, {mnpr_pkg::STAT_NOTE_ON, 4'h1}, 7'd61, 7'd91, 32'd1600);
        // clear empties a non-empty list
        queue_item(mnpr_pkg::CMD_MIDI, {mnpr_pkg::STAT_NOTE_ON, 4'h2}, 7'd40, 7'd50, 32'd50);
        queue_item(mnpr_pkg::CMD_CLEAR, 8'h00, 7'd0, 7'd0, 32'd0);
        // fill the list, then one more note-on is dropped
        for (int i = 0; i < 16; i++)
            queue_item(mnpr_pkg::CMD_MIDI, {mnpr_pkg::STAT_NOTE_ON, 4'(i)}, 7'(i * 8),
                       7'(i * 8 + 1), 32'(1000 + i * 10));
        queue_item(mnpr_pkg::CMD_MIDI, {mnpr_pkg::STAT_NOTE_ON, 4'h9}, 7'd99, 7'd77, 32'd77777);
        // full flush: some lengths positive, the rest take the flush floor
        queue_item(mnpr_pkg::CMD_FLUSH, 8'h00, 7'd0, 7'd0, 32'd1050);
        wait_quiet();
        // flush of an empty list still stops recording
        write_record_enable(1'b1);
        queue_item(mnpr_pkg::CMD_FLUSH, 8'h00, 7'd0, 7'd0, 32'd2000);
        wait_quiet();

        // Random phases: mostly well-formed on/off pairs on few notes, with noise,
        // clears and flushes. A flush ends the phase since recording stops.
        t_now   = 32'd0;
        counted = queued_total;
        phase   = 0;
        while (counted < ITEM_TARGET)
        begin
            gen_on = (phase <= HOLD_PHASE) || ($urandom_range(0, 5) != 0);
            write_record_enable(gen_on);
            len    = gen_on ? $urandom_range(20, 60) : $urandom_range(4, 10);
            on_pct = $urandom_range(35, 70);
            for (int k = 0; k < len && counted < ITEM_TARGET; k++)
            begin
                if ($urandom_range(0, 24) == 0)
                    t_now = $urandom;
                else
                    t_now = t_now + $urandom_range(0, 1500);
                chan = 4'($urandom_range(0, 15));
                note = 7'($urandom_range(0, 127));
                pick = $urandom_range(0, (phase == HOLD_PHASE) ? 97 : 99);
                if (pick < on_pct)
                begin
                    // reuse a held note now and then, so duplicates pile up
                    if (gen_notes.size() != 0 && $urandom_range(0, 2) == 0)
                        {chan, note} = gen_notes[$urandom_range(0, gen_notes.size() - 1)];
                    queue_item(mnpr_pkg::CMD_MIDI, {mnpr_pkg::STAT_NOTE_ON, chan}, note,
                               7'($urandom_range(1, 127)), t_now);
                    if (gen_on && gen_notes.size() < mnpr_pkg::PENDING_DEPTH_DEF)
                        gen_notes.insert(gen_notes.size(), {chan, note});
                end
                else if (pick < on_pct + 28)
                begin
                    if (gen_notes.size() != 0)
                    begin
                        idx = $urandom_range(0, gen_notes.size() - 1);
                        key = gen_notes[idx];
                        gen_notes.delete(idx);
                        {chan, note} = key;
                    end
                    if ($urandom_range(0, 1) == 0)
                        queue_item(mnpr_pkg::CMD_MIDI, {mnpr_pkg::STAT_NOTE_OFF, chan}, note,
                                   7'($urandom_range(0, 127)), t_now);
                    else
                        queue_item(mnpr_pkg::CMD_MIDI, {mnpr_pkg::STAT_NOTE_ON, chan}, note,
                                   7'd0, t_now);
                end
                else if (pick < 94)
                    queue_item(mnpr_pkg::CMD_MIDI, 8'($urandom_range(0, 255)), note,
                               7'($urandom_range(0, 127)), t_now);
                else if (pick < 96)
                    queue_item(CMD_SPARE, 8'($urandom_range(0, 255)), note,
                               7'($urandom_range(0, 127)), t_now);
                else if (pick < 98)
                begin
                    queue_item(mnpr_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)), note,
                               7'($urandom_range(0, 127)), t_now);
                    gen_notes.delete();
                end
                else
                begin
                    queue_item(mnpr_pkg::CMD_FLUSH, 8'($urandom_range(0, 255)), note,
                               7'($urandom_range(0, 127)), t_now);
                    gen_notes.delete();
                    counted++;
                    break;
                end
                counted++;
            end
            if (phase == HOLD_PHASE)
                hold_request = 1'b1;
            wait_quiet();
            phase++;
        end

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
